// ===== rtl/assert_macros.svh =====
// assertion macros shared by the placement pipeline
// every macro samples on i_clk and is quiet while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// plain property under the block clock and reset
`define TPUV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// implication: cond in one cycle, nxt in the next
`define TPUV_ASSERT_NEXT(lbl, cond, nxt, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (nxt)) \
        else $error(msg);
`endif

// ===== rtl/tpuv_pkg.sv =====
// shared constants, types and saturation helper for the uv placement block
// no dependencies
package tpuv_pkg;
    localparam int FRAC_BITS = 16;
    localparam int TRIG_BITS = 14;
    localparam logic signed [31:0] ONE_Q  = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [31:0] HALF_Q = 32'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [31:0] MAX32  = 32'sh7fffffff;
    localparam logic signed [31:0] MIN32  = 32'sh80000000;
    // dividend is a 34-bit signed difference, scaled by one
    localparam int DW      = 34;
    localparam int NMW     = DW + FRAC_BITS;
    localparam int QB      = 33;
    localparam int DSTEP   = 4;
    localparam int DSTAGES = (QB + DSTEP - 1) / DSTEP;
    localparam int ADDR_W  = 6;

    typedef enum logic [2:0] {
        REG_FRAME  = 3'd0,
        REG_UVROT  = 3'd1,
        REG_UCOV   = 3'd2,
        REG_VCOV   = 3'd3,
        REG_USCALE = 3'd4,
        REG_VSCALE = 3'd5,
        REG_MODE   = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [31:0] frame_rotation;
        logic [31:0] uv_rotation;
        logic [63:0] u_cov_tr;
        logic [63:0] v_cov_tr;
        logic [63:0] u_scale_off;
        logic [63:0] v_scale_off;
        logic [4:0]  mode;
    } t_cfg;

    typedef struct packed {
        logic               valid;
        logic               last;
        logic               mapped;
        logic signed [31:0] u_in;
        logic signed [31:0] v_in;
    } t_side;

    typedef struct packed {
        logic signed [DW-1:0] d;
        logic signed [31:0]   cov;
        logic                 nodiv;
        logic signed [31:0]   x;
        logic                 chk;
    } t_dlane;

    typedef struct packed {
        logic signed [31:0] q;
        logic               bad;
    } t_dres;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'(MAX32)) begin
            return MAX32;
        end else if (x < 64'(MIN32)) begin
            return MIN32;
        end
        return x[31:0];
    endfunction
endpackage

// ===== rtl/tpuv_cfg.sv =====
// configuration register file with an apb-style port
// depends on tpuv_pkg
module tpuv_cfg import tpuv_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [63:0]       i_pwdata,
    output logic [63:0]       o_prdata,
    output logic              o_pready,
    output t_cfg              o_cfg
);
    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx    = t_reg_idx'(i_paddr[ADDR_W-1:3]);
    assign w_wr     = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;
    assign o_cfg    = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_rotation <= 32'(ONE_Q >>> 2);
            r_cfg.uv_rotation    <= 32'(ONE_Q >>> 2);
            r_cfg.u_cov_tr       <= {ONE_Q, 32'd0};
            r_cfg.v_cov_tr       <= {ONE_Q, 32'd0};
            r_cfg.u_scale_off    <= {ONE_Q, ONE_Q};
            r_cfg.v_scale_off    <= {ONE_Q, 32'd0};
            r_cfg.mode           <= 5'd3;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_FRAME:  r_cfg.frame_rotation <= i_pwdata[31:0];
                REG_UVROT:  r_cfg.uv_rotation    <= i_pwdata[31:0];
                REG_UCOV:   r_cfg.u_cov_tr       <= i_pwdata;
                REG_VCOV:   r_cfg.v_cov_tr       <= i_pwdata;
                REG_USCALE: r_cfg.u_scale_off    <= i_pwdata;
                REG_VSCALE: r_cfg.v_scale_off    <= i_pwdata;
                REG_MODE:   r_cfg.mode           <= i_pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_FRAME:  o_prdata = {32'd0, r_cfg.frame_rotation};
            REG_UVROT:  o_prdata = {32'd0, r_cfg.uv_rotation};
            REG_UCOV:   o_prdata = r_cfg.u_cov_tr;
            REG_VCOV:   o_prdata = r_cfg.v_cov_tr;
            REG_USCALE: o_prdata = r_cfg.u_scale_off;
            REG_VSCALE: o_prdata = r_cfg.v_scale_off;
            REG_MODE:   o_prdata = {59'd0, r_cfg.mode};
            default:    o_prdata = 64'd0;
        endcase
    end
endmodule

// ===== rtl/tpuv_rot.sv =====
// two-stage rotation about the texture centre: products, then sum and saturate
// depends on tpuv_pkg
module tpuv_rot import tpuv_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [32:0] i_du,
    input  logic signed [32:0] i_dv,
    input  logic signed [15:0] i_c,
    input  logic signed [16:0] i_s,
    output logic signed [31:0] o_nu,
    output logic signed [31:0] o_nv
);
    logic signed [49:0] r_uc, r_vs, r_vc, r_us;
    logic signed [31:0] r_nu, r_nv;
    logic signed [50:0] w_su, w_sv;
    logic signed [63:0] w_tu, w_tv;

    always_comb begin
        w_su = 51'(r_uc) + 51'(r_vs);
        w_sv = 51'(r_vc) - 51'(r_us);
        w_tu = 64'(w_su >>> TRIG_BITS) + 64'(HALF_Q);
        w_tv = 64'(w_sv >>> TRIG_BITS) + 64'(HALF_Q);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_uc <= 50'(i_du) * 50'(i_c);
            r_vs <= 50'(i_dv) * 50'(i_s);
            r_vc <= 50'(i_dv) * 50'(i_c);
            r_us <= 50'(i_du) * 50'(i_s);
            r_nu <= sat32(w_tu);
            r_nv <= sat32(w_tv);
        end
    end

    assign o_nu = r_nu;
    assign o_nv = r_nv;
endmodule

// ===== rtl/tpuv_div.sv =====
// pipelined signed fixed-point divider for both axes, up to four quotient bits a stage
// depends on tpuv_pkg
module tpuv_div import tpuv_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  t_side  i_side,
    input  t_dlane i_lane [2],
    output t_side  o_side,
    output t_dres  o_res  [2]
);
    typedef struct packed {
        logic [31:0]   rem;
        logic [QB-1:0] quo;
        logic [QB-1:0] lo;
        logic [31:0]   dmag;
        logic          neg;
        logic          ovf;
        logic          zero;
        logic          dpos;
        logic          dneg;
        logic          nodiv;
        logic [31:0]   x;
        logic          chk;
    } t_dst;

    t_dst  r_st [2][DSTAGES+1];
    t_dst  n_st [2][DSTAGES+1];
    t_side r_sd [DSTAGES+2];
    t_dres r_res [2];

    always_comb begin
        logic signed [32:0]  cv;
        logic [32:0]         cmag;
        logic [DW-1:0]       dm;
        logic [NMW-1:0]      nm;
        logic [NMW-QB-1:0]   hi;
        logic [32:0]         t;
        int                  idx;
        for (int l = 0; l < 2; l++) begin
            cv   = 33'(i_lane[l].cov);
            cmag = cv[32] ? 33'(-cv) : 33'(cv);
            dm   = i_lane[l].d[DW-1] ? DW'(-i_lane[l].d) : DW'(i_lane[l].d);
            nm   = {dm, {FRAC_BITS{1'b0}}};
            hi   = nm[NMW-1:QB];
            n_st[l][0].dmag  = cmag[31:0];
            n_st[l][0].zero  = (i_lane[l].cov == 32'sd0);
            n_st[l][0].ovf   = (NMW'(hi) >= NMW'(cmag[31:0]));
            n_st[l][0].rem   = 32'(hi);
            n_st[l][0].quo   = '0;
            n_st[l][0].lo    = nm[QB-1:0];
            n_st[l][0].neg   = i_lane[l].d[DW-1] ^ i_lane[l].cov[31];
            n_st[l][0].dpos  = !i_lane[l].d[DW-1] && (i_lane[l].d != '0);
            n_st[l][0].dneg  = i_lane[l].d[DW-1];
            n_st[l][0].nodiv = i_lane[l].nodiv;
            n_st[l][0].x     = i_lane[l].x;
            n_st[l][0].chk   = i_lane[l].chk;
            for (int s = 0; s < DSTAGES; s++) begin
                n_st[l][s+1] = r_st[l][s];
                for (int k = 0; k < DSTEP; k++) begin
                    idx = QB - 1 - s * DSTEP - k;
                    if (idx >= 0) begin
                        t = {n_st[l][s+1].rem, r_st[l][s].lo[idx]};
                        if (t >= 33'(r_st[l][s].dmag)) begin
                            t = t - 33'(r_st[l][s].dmag);
                            n_st[l][s+1].quo[idx] = 1'b1;
                        end
                        n_st[l][s+1].rem = t[31:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 2; l++) begin
                for (int s = 0; s <= DSTAGES; s++) begin
                    r_st[l][s] <= n_st[l][s];
                end
            end
        end
    end

    // side band, valid bits reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DSTAGES + 2; s++) begin
                r_sd[s] <= '0;
            end
        end else if (i_en) begin
            r_sd[0] <= i_side;
            for (int s = 1; s < DSTAGES + 2; s++) begin
                r_sd[s] <= r_sd[s-1];
            end
        end
    end

    // sign, saturation and inside check
    always_ff @(posedge i_clk) begin
        t_dst               f;
        logic signed [31:0] q;
        if (i_en) begin
            for (int l = 0; l < 2; l++) begin
                f = r_st[l][DSTAGES];
                if (f.nodiv) begin
                    q = f.x;
                end else if (f.zero) begin
                    q = f.dpos ? MAX32 : (f.dneg ? MIN32 : 32'sd0);
                end else if (f.ovf) begin
                    q = f.neg ? MIN32 : MAX32;
                end else if (f.neg) begin
                    q = (f.quo > QB'(33'h080000000)) ? MIN32 : 32'(-f.quo);
                end else begin
                    q = (f.quo > QB'(MAX32)) ? MAX32 : f.quo[31:0];
                end
                r_res[l].q   <= q;
                r_res[l].bad <= f.chk && (q < 32'sd0 || q > ONE_Q);
            end
        end
    end

    assign o_side = r_sd[DSTAGES+1];
    assign o_res  = r_res;
endmodule

// ===== rtl/texture_placement_uv_map.sv =====
// Texture coordinate placement: one signed (u,v) item in, one placed item out.
// Input channel i_valid / o_stall carries u, v and a last marker; output channel
// o_valid / i_stall carries the placed u, v, a mapped bit and the last marker.
// An item is taken at a clock edge with valid high and stall low.
// Configuration registers sit on an apb-style port at byte address 8*index.
// Stages in order: frame rotation (products, then sum and saturate), coverage setup,
// divider (setup, nine stages of up to four quotient bits, sign and saturation),
// repeat (product, then offset), stagger and mirror, uv rotation, output register.
// Throughput is one item per cycle while the receiver does not stall; the divider stages set the depth.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and o_stall goes high; nothing is lost or repeated.
// Synchronous reset clears all valid bits and loads the register defaults;
// items may be sent on the first cycle after reset.
// Configuration must only change while no item is in flight.
// depends on tpuv_pkg, tpuv_cfg, tpuv_rot, tpuv_div and assert_macros.svh
`include "assert_macros.svh"
module texture_placement_uv_map import tpuv_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_u_in,
    input  logic signed [31:0] i_v_in,
    input  logic               i_last_in,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_u_out,
    output logic signed [31:0] o_v_out,
    output logic               o_mapped,
    output logic               o_last_out,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [ADDR_W-1:0]  i_paddr,
    input  logic [63:0]        i_pwdata,
    output logic [63:0]        o_prdata,
    output logic               o_pready
);
    t_cfg  w_cfg;
    logic  w_en;
    t_side w_in_side;
    t_side r_s1, r_s2, r_sc, r_sm, r_so, r_sf, r_sr1, r_sr2, r_out;
    t_side w_dside;
    t_dlane r_lane [2];
    t_dlane n_lane [2];
    t_dres  w_res [2];
    logic signed [31:0] w_ru, w_rv, w_nu, w_nv;
    logic signed [63:0] r_pu, r_pv;
    logic               r_in_m, r_in_o, r_in_f, r_in_r1, r_in_r2;
    logic signed [31:0] r_ou, r_ov, r_fu, r_fv;
    logic signed [31:0] r_pl_u1, r_pl_v1, r_pl_u2, r_pl_v2;
    logic signed [31:0] r_pl_u3, r_pl_v3;
    logic signed [31:0] r_out_u, r_out_v;
    logic signed [16:0] w_uv_s;

    tpuv_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (w_cfg)
    );

    assign w_en    = !(r_out.valid && i_stall);
    assign o_stall = !w_en;

    always_comb begin
        w_in_side.valid  = i_valid;
        w_in_side.last   = i_last_in;
        w_in_side.mapped = w_cfg.mode[4];
        w_in_side.u_in   = i_u_in;
        w_in_side.v_in   = i_v_in;
    end

    tpuv_rot u_frame_rot (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_du  (33'(i_u_in) - 33'(HALF_Q)),
        .i_dv  (33'(i_v_in) - 33'(HALF_Q)),
        .i_c   (w_cfg.frame_rotation[15:0]),
        .i_s   (17'($signed(w_cfg.frame_rotation[31:16]))),
        .o_nu  (w_ru),
        .o_nv  (w_rv)
    );

    // coverage and translate set up the divide
    always_comb begin
        logic signed [31:0] cov, tr, x;
        logic               wrap;
        logic signed [DW-1:0] xf;
        for (int l = 0; l < 2; l++) begin
            cov  = (l == 0) ? w_cfg.u_cov_tr[63:32] : w_cfg.v_cov_tr[63:32];
            tr   = (l == 0) ? w_cfg.u_cov_tr[31:0]  : w_cfg.v_cov_tr[31:0];
            wrap = w_cfg.mode[l];
            x    = (l == 0) ? w_ru : w_rv;
            xf   = DW'({1'b0, x[FRAC_BITS-1:0]}) - DW'({1'b0, tr[FRAC_BITS-1:0]});
            if (xf > DW'(cov)) begin
                xf = xf - DW'(ONE_Q);
            end else if (xf < 0) begin
                xf = xf + DW'(ONE_Q);
            end
            n_lane[l].cov = cov;
            n_lane[l].x   = x;
            if (cov < ONE_Q) begin
                n_lane[l].d     = xf;
                n_lane[l].nodiv = !wrap;
                n_lane[l].chk   = 1'b1;
            end else begin
                n_lane[l].d     = DW'(x) - DW'(tr);
                n_lane[l].nodiv = 1'b0;
                n_lane[l].chk   = !wrap;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lane <= n_lane;
        end
    end

    tpuv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_side  (r_sc),
        .i_lane  (r_lane),
        .o_side  (w_dside),
        .o_res   (w_res)
    );

    assign w_uv_s = -17'($signed(w_cfg.uv_rotation[31:16]));

    tpuv_rot u_uv_rot (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_du  (33'(r_fu) - 33'(HALF_Q)),
        .i_dv  (33'(r_fv) - 33'(HALF_Q)),
        .i_c   (w_cfg.uv_rotation[15:0]),
        .i_s   (w_uv_s),
        .o_nu  (w_nu),
        .o_nv  (w_nv)
    );

    // side band valid bits, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1  <= '0;
            r_s2  <= '0;
            r_sc  <= '0;
            r_sm  <= '0;
            r_so  <= '0;
            r_sf  <= '0;
            r_sr1 <= '0;
            r_sr2 <= '0;
            r_out <= '0;
        end else if (w_en) begin
            r_s1  <= w_in_side;
            r_s2  <= r_s1;
            r_sc  <= r_s2;
            r_sm  <= w_dside;
            r_so  <= r_sm;
            r_sf  <= r_so;
            r_sr1 <= r_sf;
            r_sr2 <= r_sr1;
            r_out <= r_sr2;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [31:0] su, sv;
        if (w_en) begin
            // repeat product
            r_pu   <= 64'(w_res[0].q) * 64'($signed(w_cfg.u_scale_off[63:32]));
            r_pv   <= 64'(w_res[1].q) * 64'($signed(w_cfg.v_scale_off[63:32]));
            r_in_m <= !(w_res[0].bad || w_res[1].bad);
            // offset
            r_ou   <= sat32((r_pu >>> FRAC_BITS) + 64'($signed(w_cfg.u_scale_off[31:0])));
            r_ov   <= sat32((r_pv >>> FRAC_BITS) + 64'($signed(w_cfg.v_scale_off[31:0])));
            r_in_o <= r_in_m;
            // stagger, then mirror u and v
            su = r_ou;
            sv = r_ov;
            if (w_cfg.mode[2] && r_ov[FRAC_BITS]) begin
                su = sat32(64'(r_ou) + 64'(HALF_Q));
            end
            if (w_cfg.mode[3]) begin
                if (su[FRAC_BITS]) begin
                    su = sat32(64'(su & ~(ONE_Q - 32'sd1)) * 2 + 64'(ONE_Q) - 64'(su));
                end
                if (sv[FRAC_BITS]) begin
                    sv = sat32(64'(sv & ~(ONE_Q - 32'sd1)) * 2 + 64'(ONE_Q) - 64'(sv));
                end
            end
            r_fu    <= su;
            r_fv    <= sv;
            r_pl_u1 <= r_ou;
            r_pl_v1 <= r_ov;
            r_in_f  <= r_in_o;
            r_pl_u2 <= r_pl_u1;
            r_pl_v2 <= r_pl_v1;
            r_in_r1 <= r_in_f;
            r_in_r2 <= r_in_r1;
            // final select: pass through, rotated or placed
            if (!r_sr2.mapped) begin
                r_out_u <= r_sr2.u_in;
                r_out_v <= r_sr2.v_in;
            end else if (r_in_r2) begin
                r_out_u <= w_nu;
                r_out_v <= w_nv;
            end else begin
                r_out_u <= r_pl_u3;
                r_out_v <= r_pl_v3;
            end
        end
    end

    // placed values pass through an extra register (r_pl_u3, r_pl_v3) to line up with the rotation output
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pl_u3 <= r_pl_u2;
            r_pl_v3 <= r_pl_v2;
        end
    end

    assign o_valid    = r_out.valid;
    assign o_u_out    = r_out_u;
    assign o_v_out    = r_out_v;
    assign o_mapped   = r_out.mapped;
    assign o_last_out = r_out.last;

    `TPUV_ASSERT_NEXT(a_enter, i_valid && !o_stall, r_s1.valid, "accepted item missing in stage one")
    `TPUV_ASSERT_NEXT(a_freeze, o_stall, $stable(r_s1) && $stable(r_sr2), "pipeline moved while stalled")
    `TPUV_ASSERT(a_rise, $rose(o_valid) |-> $past(w_en), "result appeared during a stall")
endmodule

// ===== tb/texture_placement_uv_map_test.sv =====
// testbench for the uv placement block: directed table then random coordinates
// expected items come from a fixed-point model of the placement path
// depends on tpuv_pkg and the texture_placement_uv_map rtl
module texture_placement_uv_map_test;
    import tpuv_pkg::*;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_valid = 0;
    logic               o_stall;
    logic signed [31:0] i_u_in = 0;
    logic signed [31:0] i_v_in = 0;
    logic               i_last_in = 0;
    logic               o_valid;
    logic               i_stall = 0;
    logic signed [31:0] o_u_out;
    logic signed [31:0] o_v_out;
    logic               o_mapped;
    logic               o_last_out;
    logic               i_psel = 0;
    logic               i_penable = 0;
    logic               i_pwrite = 0;
    logic [ADDR_W-1:0]  i_paddr = 0;
    logic [63:0]        i_pwdata = 0;
    logic [63:0]        o_prdata;
    logic               o_pready;

    typedef struct packed {
        logic signed [31:0] u;
        logic signed [31:0] v;
        logic               mapped;
        logic               last;
    } t_placed;

    typedef struct {
        logic signed [31:0] u;
        logic signed [31:0] v;
        logic               last;
        bit                 known;
        t_placed            res;
    } t_vec;

    texture_placement_uv_map DUT (.*);

    always #4 i_clk = ~i_clk;

    // shadow copy of the registers
    logic [31:0] m_frame, m_uvrot;
    logic [63:0] m_ucov, m_vcov, m_uscale, m_vscale;
    logic [4:0]  m_mode;

    t_placed placed_q[$];
    int      fail_cnt = 0;
    int      cycle_cnt = 0;
    int      send_idle = 0;
    int      recv_stall = 0;
    bit      hold_off = 0;

    function automatic longint clip32(longint x);
        if (x > 64'sh7fffffff) return 64'sh7fffffff;
        if (x < -64'sh80000000) return -64'sh80000000;
        return x;
    endfunction

    function automatic longint fl_shift(longint x, int n);
        return x >>> n;
    endfunction

    function automatic longint frac_of(longint x);
        return x & ((64'sd1 <<< FRAC_BITS) - 1);
    endfunction

    function automatic longint qdiv(longint x, longint cov);
        if (cov == 0) return x > 0 ? 64'sh7fffffff : (x < 0 ? -64'sh80000000 : 0);
        return clip32((x * (64'sd1 <<< FRAC_BITS)) / cov);
    endfunction

    function automatic longint place_axis(longint x, logic [63:0] ct, logic [63:0] so,
                                          bit wrap, inout bit in_range);
        longint one, cov, tr, rep, off;
        one = 64'sd1 <<< FRAC_BITS;
        cov = longint'($signed(ct[63:32]));
        tr  = longint'($signed(ct[31:0]));
        rep = longint'($signed(so[63:32]));
        off = longint'($signed(so[31:0]));
        if (cov < one) begin
            if (wrap) begin
                x = frac_of(x) - frac_of(tr);
                if (x > cov) x -= one;
                else if (x < 0) x += one;
                x = qdiv(x, cov);
            end
            if (x < 0 || x > one) in_range = 0;
        end else begin
            x = qdiv(x - tr, cov);
            if (!wrap && (x < 0 || x > one)) in_range = 0;
        end
        return clip32(fl_shift(x * rep, FRAC_BITS) + off);
    endfunction

    function automatic t_placed place_coord(logic signed [31:0] ui, logic signed [31:0] vi,
                                            logic li);
        t_placed r;
        longint u, v, c, s, du, dv, tu, tv, half, one;
        bit in_range;
        half = 64'sd1 <<< (FRAC_BITS - 1);
        one = 64'sd1 <<< FRAC_BITS;
        u = ui;
        v = vi;
        in_range = 1;
        r.mapped = m_mode[4];
        r.last = li;
        if (m_mode[4]) begin
            c = longint'($signed(m_frame[15:0]));
            s = longint'($signed(m_frame[31:16]));
            du = u - half;
            dv = v - half;
            tu = du * c + dv * s;
            tv = dv * c - du * s;
            u = clip32(fl_shift(tu, TRIG_BITS) + half);
            v = clip32(fl_shift(tv, TRIG_BITS) + half);
            u = place_axis(u, m_ucov, m_uscale, m_mode[0], in_range);
            v = place_axis(v, m_vcov, m_vscale, m_mode[1], in_range);
            if (in_range) begin
                if (m_mode[2] && fl_shift(v, FRAC_BITS) % 2 != 0) u = clip32(u + half);
                if (m_mode[3]) begin
                    if (fl_shift(u, FRAC_BITS) % 2 != 0)
                        u = clip32(2 * (u - frac_of(u)) + one - u);
                    if (fl_shift(v, FRAC_BITS) % 2 != 0)
                        v = clip32(2 * (v - frac_of(v)) + one - v);
                end
                c = longint'($signed(m_uvrot[15:0]));
                s = longint'($signed(m_uvrot[31:16]));
                du = u - half;
                dv = v - half;
                tu = du * c - dv * s;
                tv = du * s + dv * c;
                u = clip32(fl_shift(tu, TRIG_BITS) + half);
                v = clip32(fl_shift(tv, TRIG_BITS) + half);
            end
        end
        r.u = u[31:0];
        r.v = v[31:0];
        return r;
    endfunction

    task automatic reg_write(t_reg_idx idx, logic [63:0] val);
        @(posedge i_clk);
        i_psel <= 1;
        i_penable <= 0;
        i_pwrite <= 1;
        i_paddr <= ADDR_W'(8 * idx);
        i_pwdata <= val;
        @(posedge i_clk);
        i_penable <= 1;
        do @(posedge i_clk); while (!o_pready);
        i_psel <= 0;
        i_penable <= 0;
        i_pwrite <= 0;
        case (idx)
            REG_FRAME:  m_frame = val[31:0];
            REG_UVROT:  m_uvrot = val[31:0];
            REG_UCOV:   m_ucov = val;
            REG_VCOV:   m_vcov = val;
            REG_USCALE: m_uscale = val;
            REG_VSCALE: m_vscale = val;
            REG_MODE:   m_mode = val[4:0];
            default: ;
        endcase
    endtask

    // drive one item, hold until accepted
    task automatic send_coord(t_vec t);
        if (send_idle > 0 && $urandom_range(99) < send_idle) begin
            i_valid <= 0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle);
        end
        i_valid <= 1;
        i_u_in <= t.u;
        i_v_in <= t.v;
        i_last_in <= t.last;
        do @(posedge i_clk); while (o_stall);
        placed_q.push_back(t.known ? t.res : place_coord(t.u, t.v, t.last));
    endtask

    task automatic drain;
        i_valid <= 0;
        while (placed_q.size() > 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    // receiver stall
    always @(posedge i_clk) begin
        i_stall <= hold_off || (recv_stall > 0 && $urandom_range(99) < recv_stall);
    end

    // result checker
    always @(posedge i_clk) begin
        t_placed e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (placed_q.size() == 0) begin
                $display("%0t: unexpected item u=%h v=%h", $time, o_u_out, o_v_out);
                fail_cnt++;
            end else begin
                e = placed_q.pop_front();
                if (e.u !== o_u_out || e.v !== o_v_out || e.mapped !== o_mapped ||
                    e.last !== o_last_out) begin
                    $display("%0t: mismatch expected u=%h v=%h m=%b l=%b got u=%h v=%h m=%b l=%b",
                             $time, e.u, e.v, e.mapped, e.last,
                             o_u_out, o_v_out, o_mapped, o_last_out);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > 400000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed($urandom_range(196608)) - 65536;
            2: return $signed($urandom_range(65536));
            default: return $signed($urandom_range(2000000)) - 1000000;
        endcase
    endfunction

    function automatic logic [31:0] rand_trig();
        if ($urandom_range(3) == 0) return $urandom;
        return {16'($signed($urandom_range(32768)) - 16384),
                16'($signed($urandom_range(32768)) - 16384)};
    endfunction

    function automatic logic [63:0] rand_pair();
        case ($urandom_range(4))
            0: return {$urandom, $urandom};
            1: return {32'($urandom_range(65535)), 32'($signed($urandom_range(131072)) - 65536)};
            2: return {32'($urandom_range(262144, 65536)), 32'($urandom_range(65536))};
            3: return {32'd0, $urandom};
            default: return {32'($signed($urandom_range(65536)) - 65536), $urandom};
        endcase
    endfunction

    initial begin
        t_vec dir[$];
        t_vec t;
        int   phase;
        m_frame = 32'd16384;
        m_uvrot = 32'd16384;
        m_ucov = 64'h0001_0000_0000_0000;
        m_vcov = 64'h0001_0000_0000_0000;
        m_uscale = 64'h0001_0000_0001_0000;
        m_vscale = 64'h0001_0000_0000_0000;
        m_mode = 5'd3;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;

        // after reset no mapper: pass through
        dir.push_back('{32'sh7fffffff, 32'sh80000000, 1, 1, '{32'sh7fffffff, 32'sh80000000, 0, 1}});
        dir.push_back('{32'sh80000000, 32'sh7fffffff, 0, 1, '{32'sh80000000, 32'sh7fffffff, 0, 0}});
        dir.push_back('{32'sd0, -32'sd1, 1, 1, '{32'sd0, -32'sd1, 0, 1}});
        dir.push_back('{32'sh12345678, 32'sh0000ffff, 0, 0, '0});
        foreach (dir[i]) send_coord(dir[i]);
        drain();
        dir.delete();

        // mapper on, stagger and mirror, wrap both
        reg_write(REG_MODE, 64'd31);
        dir.push_back('{32'sd0, 32'sd0, 0, 0, '0});
        dir.push_back('{32'sh7fffffff, 32'sh7fffffff, 1, 0, '0});
        dir.push_back('{32'sh80000000, 32'sh80000000, 0, 0, '0});
        dir.push_back('{32'sd32768, 32'sd98304, 0, 0, '0});
        dir.push_back('{32'sd65536, 32'sd65536, 1, 0, '0});
        reg_write(REG_UCOV, 64'h0000_8000_0000_4000);
        reg_write(REG_VCOV, 64'h0000_0000_0000_0000);
        foreach (dir[i]) send_coord(dir[i]);
        drain();
        reg_write(REG_VCOV, 64'hffff_8000_0001_0000);
        reg_write(REG_USCALE, 64'h7fff_ffff_7fff_ffff);
        reg_write(REG_VSCALE, 64'h8000_0000_8000_0000);
        reg_write(REG_FRAME, 64'h4000_0000);
        reg_write(REG_UVROT, 64'h8000_8000);
        foreach (dir[i]) send_coord(dir[i]);
        drain();
        dir.delete();

        for (phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_idle = 0; recv_stall = 0; end
                1: begin send_idle = 71; recv_stall = 0; end
                2: begin send_idle = 0; recv_stall = 71; end
                default: begin send_idle = 32; recv_stall = 32; end
            endcase
            reg_write(REG_FRAME, rand_trig());
            reg_write(REG_UVROT, rand_trig());
            reg_write(REG_UCOV, rand_pair());
            reg_write(REG_VCOV, rand_pair());
            reg_write(REG_USCALE, $urandom_range(1) ? rand_pair() : 64'h0001_0000_0000_0000);
            reg_write(REG_VSCALE, $urandom_range(1) ? rand_pair() : 64'h0002_0000_0000_8000);
            reg_write(REG_MODE, phase == 7 ? 64'd0 : 64'($urandom_range(31) | 16));
            if (phase == 2) begin
                // long receiver hold so the pipeline fills up
                fork
                    begin
                        hold_off = 1;
                        repeat (80) @(posedge i_clk);
                        hold_off = 0;
                    end
                join_none
            end
            repeat (235) begin
                t.u = rand_coord();
                t.v = rand_coord();
                t.last = $urandom_range(1);
                t.known = 0;
                send_coord(t);
            end
            drain();
        end

        if (fail_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

// ===== texture_placement_uv_map.f =====
+incdir+rtl
rtl/tpuv_pkg.sv
rtl/tpuv_cfg.sv
rtl/tpuv_rot.sv
rtl/tpuv_div.sv
rtl/texture_placement_uv_map.sv
tb/texture_placement_uv_map_test.sv
